>>> rtl/cdx_pkg.sv
package cdx_pkg;

  // field and register widths
  localparam int unsigned METHOD_W    = 2;
  localparam int unsigned LENGTH_W    = 31;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned APB_DATA_W  = 32;
  localparam int unsigned APB_ADDR_W  = 3;
  localparam int unsigned CDX_COUNT_BITS = 31;

  // reset values of the registers
  localparam logic [METHOD_W-1:0] METHOD_RESET = 2'd0;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 31'd1;

  // method codes
  typedef enum logic [METHOD_W-1:0] {
    METHOD_PLAIN = 2'd0,
    METHOD_FIXUP = 2'd1,
    METHOD_ALT   = 2'd2,
    METHOD_SPARE = 2'd3
  } method_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_METHOD = 1'b0,
    REG_LENGTH = 1'b1
  } reg_idx_t;

  // scramble constants
  localparam logic [BYTE_W-1:0] MULT_STD   = 8'h6d;
  localparam logic [BYTE_W-1:0] MULT_ALT   = 8'had;
  localparam logic [BYTE_W-1:0] FIXUP_BYTE = 8'h0d;
  localparam logic [3:0]        LANE_FIX_A = 4'd5;
  localparam logic [3:0]        LANE_FIX_B = 4'd6;

  // configuration seen by the datapath
  typedef struct packed {
    logic [METHOD_W-1:0] method;
    logic [LENGTH_W-1:0] buffer_length;
    logic                rearm;
    logic [BYTE_W-1:0]   seed;
  } cfg_t;

  // 16-byte key, indexed by position mod 16
  function automatic logic [BYTE_W-1:0] key_byte(input logic [3:0] lane);
    logic [BYTE_W-1:0] k;
    case (lane)
      4'd0:    k = 8'h4f;
      4'd1:    k = 8'hd0;
      4'd2:    k = 8'ha0;
      4'd3:    k = 8'hac;
      4'd4:    k = 8'h4a;
      4'd5:    k = 8'h5b;
      4'd6:    k = 8'hb9;
      4'd7:    k = 8'he5;
      4'd8:    k = 8'h93;
      4'd9:    k = 8'h79;
      4'd10:   k = 8'h45;
      4'd11:   k = 8'ha5;
      4'd12:   k = 8'hc1;
      4'd13:   k = 8'hcb;
      4'd14:   k = 8'h31;
      4'd15:   k = 8'h93;
      default: k = 8'h00;
    endcase
    return k;
  endfunction

endpackage

>>> rtl/cdx_regs.sv
module cdx_regs
  import cdx_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [METHOD_W-1:0] method;
  logic [LENGTH_W-1:0] buffer_length;
  logic                wr_en;
  reg_idx_t            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[2]);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      method        <= METHOD_RESET;
      buffer_length <= LENGTH_RESET;
    end else if (wr_en) begin
      unique case (idx)
        REG_METHOD: method        <= pwdata[METHOD_W-1:0];
        REG_LENGTH: buffer_length <= pwdata[LENGTH_W-1:0];
        default:    method        <= method;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_METHOD: prdata = {{(APB_DATA_W-METHOD_W){1'b0}}, method};
      REG_LENGTH: prdata = {{(APB_DATA_W-LENGTH_W){1'b0}}, buffer_length};
      default:    prdata = '0;
    endcase
  end

  // any write rearms; seed follows a length being written this cycle
  always_comb begin
    cfg.method        = method;
    cfg.buffer_length = buffer_length;
    cfg.rearm         = wr_en;
    cfg.seed          = (wr_en && idx == REG_LENGTH) ? pwdata[BYTE_W-1:0]
                                                     : buffer_length[BYTE_W-1:0];
  end

endmodule

>>> rtl/cdx_core.sv
module cdx_core
  import cdx_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CDX_COUNT_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  cfg_t              cfg,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] data_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] data_out,
  output logic              last
);

  logic [COUNT_BITS-1:0]   position;
  logic [BYTE_W-1:0]       chain_byte;
  logic [COUNT_BITS-1:0]   pos_inc;
  logic [3:0]              lane;
  logic [BYTE_W-1:0]       mult;
  logic [2*BYTE_W-1:0]     prod;
  logic [BYTE_W-1:0]       x;
  logic [BYTE_W-1:0]       result;
  logic                    is_last;
  logic                    fix;
  logic                    accept;

  // input transfer whenever the output register is free or draining
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // per-byte datapath
  assign lane    = position[3:0];
  assign pos_inc = position + 1'b1;
  assign is_last = (pos_inc == cfg.buffer_length[COUNT_BITS-1:0]);
  assign mult    = (cfg.method == METHOD_ALT) ? MULT_ALT : MULT_STD;
  assign prod    = position[BYTE_W-1:0] * mult;
  assign x       = data_in ^ key_byte(lane) ^ prod[BYTE_W-1:0];
  assign fix     = (cfg.method != METHOD_PLAIN) &&
                   ((lane == LANE_FIX_B) || ((lane == LANE_FIX_A) && !is_last));
  assign result  = x ^ chain_byte ^ (fix ? FIXUP_BYTE : '0);

  // position and chain state
  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      chain_byte <= LENGTH_RESET[BYTE_W-1:0];
    end else if (cfg.rearm) begin
      position   <= '0;
      chain_byte <= cfg.seed;
    end else if (accept) begin
      position   <= is_last ? '0 : pos_inc;
      chain_byte <= is_last ? cfg.buffer_length[BYTE_W-1:0] : x;
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      data_out <= result;
      last     <= is_last;
    end
  end

  // checks
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("no result after input transfer");

  a_rearm_state: assert property (@(posedge clk) disable iff (rst)
    cfg.rearm |=> (position == '0) && (chain_byte == $past(cfg.seed)))
    else $error("config write did not rearm");

  a_advance: assert property (@(posedge clk) disable iff (rst)
    (accept && !is_last && !cfg.rearm) |=>
      (position == $past(pos_inc)) && (chain_byte == $past(x)))
    else $error("position or chain did not advance");

  a_last_rearm: assert property (@(posedge clk) disable iff (rst)
    (accept && is_last && !cfg.rearm) |=>
      (position == '0) && last && out_valid)
    else $error("last byte did not rearm");

endmodule

>>> rtl/chained_xor_descrambler.sv
// chained xor descrambler
//
// Descrambles a buffer one byte per transfer. Program method and
// buffer_length over the APB port (method at 0x0, buffer_length at 0x4)
// while the block is idle; any register write restarts the buffer at
// position 0 with the chain seeded from the low byte of buffer_length.
// Bytes enter on data_in (in_valid/in_ready) and leave on data_out with
// last (out_valid/out_ready); last marks the final byte, after which the
// block restarts by itself for the next buffer.
// A byte taken on data_in is registered and shown from the next cycle.
// Throughput is one byte per cycle, set by the single output register
// and the 8-bit chain register that links neighboring bytes.
// When the receiver stalls, the output register holds its byte and
// in_ready drops until it is taken; a byte may enter in the same cycle
// the held one leaves.
// Reset (rst, synchronous) empties the output register, sets method 0,
// buffer_length 1 and restarts the position count.
module chained_xor_descrambler
  import cdx_pkg::*;
#(
  parameter int unsigned COUNT_BITS = CDX_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [BYTE_W-1:0]     data_in,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     data_out,
  output logic                  last
);

  cfg_t cfg;

  // configuration registers
  cdx_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // byte datapath and output register
  cdx_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_in   (data_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out),
    .last      (last)
  );

endmodule
